>>> sv/svwap_pkg.sv
package svwap_pkg;

   localparam int PRICE_W = 24;              // price field width
   localparam int VOL_W   = 24;              // volume field width
   localparam int TAG_W   = 32;              // session tag width
   localparam int SUM_W   = PRICE_W + 2;     // high + low + close
   localparam int PROD_W  = SUM_W + VOL_W;   // typical sum times volume
   localparam int PV_W    = 64;              // price-volume running sum
   localparam int VS_W    = 48;              // volume running sum
   localparam int Q_W     = 32;              // quotient / vwap width

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_LAUNCH,
      ST_DIV,
      ST_PUT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

>>> sv/svwap_div.sv
module svwap_div #(
   parameter int FRAC_BITS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            div_start,
   input  logic [svwap_pkg::PV_W-1:0]      div_num,
   input  logic [svwap_pkg::VS_W-1:0]      div_den,
   output logic [svwap_pkg::Q_W-1:0]       div_quot,
   output svwap_pkg::div_status_type       div_status
);
   import svwap_pkg::*;

   localparam int NUM_W = PV_W + FRAC_BITS;
   localparam int CNT_W = $clog2(Q_W);

   logic [NUM_W-1:0]  scaled;
   logic [VS_W-1:0]   head;
   logic [VS_W:0]     shifted;
   logic [VS_W+1:0]   diff;
   logic              fits;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [VS_W-1:0]   rem_ff, rem_in;
   logic [VS_W-1:0]   den_ff, den_in;
   logic [Q_W-1:0]    low_ff, low_in;
   logic [Q_W-1:0]    quot_ff, quot_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // Quotient fits in Q_W bits exactly when the dividend's head is below the divisor.
   assign scaled  = NUM_W'(div_num) << FRAC_BITS;
   assign head    = VS_W'(scaled[NUM_W-1:Q_W]);
   assign shifted = {rem_ff, low_ff[Q_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};
   assign fits    = (head < div_den);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      if (div_start) begin
         if (div_den == '0) begin
            quot_in = '0;
            done_in = 1'b1;
         end else if (!fits) begin
            quot_in = '1;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            rem_in  = head;
            den_in  = div_den;
            low_in  = scaled[Q_W-1:0];
            quot_in = '0;
            cnt_in  = '0;
         end
      end else if (busy_ff) begin
         // One restoring step: bring down a bit, subtract if it fits.
         if (!diff[VS_W+1]) begin
            rem_in = diff[VS_W-1:0];
         end else begin
            rem_in = shifted[VS_W-1:0];
         end
         quot_in = {quot_ff[Q_W-2:0], !diff[VS_W+1]};
         low_in  = {low_ff[Q_W-2:0], 1'b0};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   assign div_quot          = quot_ff;
   assign div_status.busy   = busy_ff;
   assign div_status.done   = done_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still iterating");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < den_ff))
      else $error("partial remainder not below divisor");

   a_last_step_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !div_start && cnt_ff == CNT_W'(Q_W - 1)) |=> done_ff)
      else $error("last division step did not finish");

endmodule

>>> sv/session_vwap.sv
// session_vwap: volume weighted typical price with per-session restart.
//
// Input channel (req_): one market bar per item, high/low/close prices in
// ticks, volume and a session tag. Result channel (rsp_): one item per bar,
// vwap in Q24.8 (FRAC_BITS fraction bits) and the saturation flag.
// A first bar after reset, or a bar whose tag differs from the previous
// bar's, clears both running sums and the flag before the bar is added.
//
// Timing: a new bar is taken only once the previous result has been handed
// to the output register. Each bar goes through a bit-serial multiply (one
// volume bit per cycle) and then a restoring divider (one quotient bit per
// cycle). When the volume sum is zero or the quotient saturates, the divider
// finishes at once without iterating.
// A finished result waits in the output register while the next bar is
// accepted and worked on; a stalled receiver holds only the final handoff.
// Reset (synchronous, active high) empties the output register, returns to
// idle and forgets the previous session tag.
module session_vwap #(
   parameter int PRICE_BITS = 24,
   parameter int FRAC_BITS  = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [svwap_pkg::PRICE_W-1:0]      req_high_price,
   input  logic [svwap_pkg::PRICE_W-1:0]      req_low_price,
   input  logic [svwap_pkg::PRICE_W-1:0]      req_close_price,
   input  logic [svwap_pkg::VOL_W-1:0]        req_volume,
   input  logic [svwap_pkg::TAG_W-1:0]        req_session_tag,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [svwap_pkg::Q_W-1:0]          rsp_vwap,
   output logic                               rsp_saturated
);
   import svwap_pkg::*;

   localparam int MCNT_W = $clog2(VOL_W);
   localparam logic [PRICE_W-1:0] PRICE_MASK = {PRICE_W{1'b1}} >> (PRICE_W - PRICE_BITS);

   state_type            state_ff, state_in;
   logic                 accept;
   logic                 load_out;
   logic                 div_start;

   // bar registers
   logic [SUM_W-1:0]     mcand_ff;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [VOL_W-1:0]     vol_ff;
   logic [MCNT_W-1:0]    mul_cnt_ff;
   logic                 restart_ff;

   // session state
   logic                 seen_ff;
   logic [TAG_W-1:0]     prev_ff;
   logic [PV_W-1:0]      pv_ff, pv_in;
   logic [VS_W-1:0]      vs_ff, vs_in;
   logic                 sat_ff, sat_in;

   // output register
   logic                 rsp_valid_ff;
   logic [Q_W-1:0]       rsp_vwap_ff;
   logic                 rsp_sat_ff;

   logic [SUM_W-1:0]     typ_sum;
   logic [SUM_W:0]       mul_add;
   logic [PV_W-1:0]      pv_base;
   logic [VS_W-1:0]      vs_base;
   logic [PV_W:0]        pv_add;
   logic [VS_W:0]        vs_add;
   logic [VOL_W+1:0]     vs_term;

   logic [Q_W-1:0]       div_quot;
   div_status_type       div_status;

   // Control: next state and strobes.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      div_start = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_cnt_ff == MCNT_W'(VOL_W - 1)) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            state_in = ST_LAUNCH;
         end
         ST_LAUNCH: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_status.done) begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            // hand over once the output register is free or being emptied
            if (!rsp_valid_ff || rsp_ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Typical price sum of the masked prices.
   assign typ_sum = SUM_W'(req_high_price & PRICE_MASK)
                  + SUM_W'(req_low_price & PRICE_MASK)
                  + SUM_W'(req_close_price & PRICE_MASK);

   // Shift-add multiply: the low half of prod_ff starts as the volume and
   // shifts out one multiplier bit per cycle.
   assign mul_add = {1'b0, prod_ff[PROD_W-1:VOL_W]}
                  + (prod_ff[0] ? {1'b0, mcand_ff} : {(SUM_W + 1){1'b0}});
   assign prod_in = {mul_add, prod_ff[VOL_W-1:1]};

   // Accumulate with session restart and saturation.
   assign pv_base = restart_ff ? '0 : pv_ff;
   assign vs_base = restart_ff ? '0 : vs_ff;
   assign vs_term = {1'b0, vol_ff, 1'b0} + {2'b00, vol_ff};
   assign pv_add  = {1'b0, pv_base} + (PV_W + 1)'(prod_ff);
   assign vs_add  = {1'b0, vs_base} + (VS_W + 1)'(vs_term);

   always_comb begin
      sat_in = restart_ff ? 1'b0 : sat_ff;
      pv_in  = pv_add[PV_W-1:0];
      vs_in  = vs_add[VS_W-1:0];
      if (pv_add[PV_W]) begin
         pv_in  = '1;
         sat_in = 1'b1;
      end
      if (vs_add[VS_W]) begin
         vs_in  = '1;
         sat_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (accept) begin
         seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mcand_ff   <= typ_sum;
         prod_ff    <= PROD_W'(req_volume);
         vol_ff     <= req_volume;
         mul_cnt_ff <= '0;
         restart_ff <= !seen_ff || (req_session_tag != prev_ff);
         prev_ff    <= req_session_tag;
      end else if (state_ff == ST_MUL) begin
         prod_ff    <= prod_in;
         mul_cnt_ff <= mul_cnt_ff + MCNT_W'(1);
      end
      if (state_ff == ST_ACC) begin
         pv_ff  <= pv_in;
         vs_ff  <= vs_in;
         sat_ff <= sat_in;
      end
   end

   svwap_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .div_start  (div_start),
      .div_num    (pv_ff),
      .div_den    (vs_ff),
      .div_quot   (div_quot),
      .div_status (div_status)
   );

   // Output register: load from the divider, drop once the item is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_vwap_ff <= div_quot;
         rsp_sat_ff  <= sat_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_vwap      = rsp_vwap_ff;
   assign rsp_saturated = rsp_sat_ff;

   a_launch_idle_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LAUNCH) |-> !div_status.busy)
      else $error("divider launched while busy");

   a_zero_volume_zero_pv: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LAUNCH && vs_ff == '0) |-> (pv_ff == '0))
      else $error("price-volume sum nonzero with zero volume sum");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV))
      else $error("divider result outside the wait state");

   a_load_from_put: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_PUT))
      else $error("result appeared without a handoff");

endmodule

>>> sim/session_vwap_test.sv
`timescale 1ns / 1ps

module session_vwap_test;
   import svwap_pkg::*;

   localparam int PRICE_BITS  = 24;
   localparam int FRAC_BITS   = 8;
   localparam int QUIET_LIMIT = 3000;   // cycles with no item moving on either channel
   localparam int HOLD_CYCLES = 600;    // long receiver hold-off, long enough to fill the block
   localparam int SETTLE      = 80;     // extra wait after the last result before the verdict
   // Bars at full price and full volume in one session, driving the sums high.
   localparam int FULL_BARS   = 40;
   localparam int RANDOM_BARS = 1550;

   localparam logic [PRICE_W-1:0] PX_MAX  = '1;
   localparam logic [VOL_W-1:0]   VOL_MAX = '1;
   localparam logic [PRICE_W-1:0] PX_MASK = PRICE_W'((64'd1 << PRICE_BITS) - 1);

   typedef struct {
      logic [PRICE_W-1:0] px_high;
      logic [PRICE_W-1:0] px_low;
      logic [PRICE_W-1:0] px_close;
      logic [VOL_W-1:0]   qty;
      logic [TAG_W-1:0]   tag;
      int unsigned        gap_after;    // idle cycles on the input once this bar is taken
      bit                 drain_first;  // hold this bar until every pending result is back
   } bar_type;

   typedef struct {
      logic [Q_W-1:0] vwap;
      logic           saturated;
   } vwap_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [PRICE_W-1:0]  req_high_price = '0;
   logic [PRICE_W-1:0]  req_low_price = '0;
   logic [PRICE_W-1:0]  req_close_price = '0;
   logic [VOL_W-1:0]    req_volume = '0;
   logic [TAG_W-1:0]    req_session_tag = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [Q_W-1:0]      rsp_vwap;
   logic                rsp_saturated;

   session_vwap #(
      .PRICE_BITS(PRICE_BITS),
      .FRAC_BITS(FRAC_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_high_price(req_high_price),
      .req_low_price(req_low_price),
      .req_close_price(req_close_price),
      .req_volume(req_volume),
      .req_session_tag(req_session_tag),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_vwap(rsp_vwap),
      .rsp_saturated(rsp_saturated)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Bars waiting to be driven, and the averages still owed by the block.
   bar_type     bar_queue[$];
   vwap_type    vwap_expected[$];

   int unsigned bars_offered = 0;     // driver side: bars put on the input
   int unsigned bars_accepted = 0;    // monitor side: bars taken by the block
   int unsigned results_checked = 0;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;
   int unsigned hold_at = 0;          // result count at which the receiver holds off

   // Session accumulator mirrored from the block's behavior.
   logic [PV_W-1:0]  pv_sum = '0;
   logic [VS_W-1:0]  vol_sum = '0;
   logic [TAG_W-1:0] last_tag = '0;
   bit               bar_seen = 1'b0;
   bit               sum_sat = 1'b0;

   // Fold one bar into the session sums and return the average the block must report.
   function automatic vwap_type accumulate_bar(input bar_type b);
      logic [PV_W-1:0]           px_h;
      logic [PV_W-1:0]           px_l;
      logic [PV_W-1:0]           px_c;
      logic [PV_W-1:0]           qty_w;
      logic [PV_W-1:0]           term;
      logic [PV_W:0]             pv_next;
      logic [VS_W:0]             vs_term;
      logic [VS_W:0]             vs_next;
      logic [PV_W+FRAC_BITS-1:0] num;
      logic [PV_W+FRAC_BITS-1:0] den;
      logic [PV_W+FRAC_BITS-1:0] quot;
      vwap_type                  r;
      // restart on the first bar after reset and on any change of tag
      if (!bar_seen || b.tag != last_tag) begin
         pv_sum  = '0;
         vol_sum = '0;
         sum_sat = 1'b0;
      end
      bar_seen = 1'b1;
      last_tag = b.tag;

      px_h  = PV_W'(b.px_high & PX_MASK);
      px_l  = PV_W'(b.px_low & PX_MASK);
      px_c  = PV_W'(b.px_close & PX_MASK);
      qty_w = PV_W'(b.qty);
      term  = (px_h + px_l + px_c) * qty_w;

      // saturate rather than wrap, and remember it for the rest of the session
      pv_next = {1'b0, pv_sum} + {1'b0, term};
      if (pv_next[PV_W]) begin
         pv_sum  = '1;
         sum_sat = 1'b1;
      end else begin
         pv_sum = pv_next[PV_W-1:0];
      end

      vs_term = (VS_W + 1)'(b.qty);
      vs_term = vs_term + (vs_term << 1);
      vs_next = {1'b0, vol_sum} + vs_term;
      if (vs_next[VS_W]) begin
         vol_sum = '1;
         sum_sat = 1'b1;
      end else begin
         vol_sum = vs_next[VS_W-1:0];
      end

      // floor(pv * 2^FRAC / vs), clamped to the output width; zero when no volume yet
      if (vol_sum == '0) begin
         r.vwap = '0;
      end else begin
         num  = (PV_W + FRAC_BITS)'(pv_sum);
         num  = num << FRAC_BITS;
         den  = (PV_W + FRAC_BITS)'(vol_sum);
         quot = num / den;
         r.vwap = ((quot >> Q_W) != 0) ? '1 : quot[Q_W-1:0];
      end
      r.saturated = sum_sat;
      return r;
   endfunction

   task automatic queue_bar(input logic [PRICE_W-1:0] h, l, c, input logic [VOL_W-1:0] v,
                            input logic [TAG_W-1:0] t, input int unsigned gap,
                            input bit drain);
      bar_type b;
      b.px_high     = h;
      b.px_low      = l;
      b.px_close    = c;
      b.qty         = v;
      b.tag         = t;
      b.gap_after   = gap;
      b.drain_first = drain;
      bar_queue.push_back(b);
   endtask

   // Price near a session's base level, with the odd outlier or extreme mixed in.
   function automatic logic [PRICE_W-1:0] near_price(input logic [PRICE_W-1:0] base);
      int unsigned      r;
      logic [PRICE_W:0] p;
      r = $urandom_range(0, 99);
      if (r < 10) return PRICE_W'($urandom);
      if (r < 13) return '0;
      if (r < 16) return '1;
      p = {1'b0, base} + (PRICE_W + 1)'($urandom_range(0, 64));
      return p[PRICE_W] ? '1 : p[PRICE_W-1:0];
   endfunction

   task automatic log_mismatch(input string what, input vwap_type want);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at result %0d (%s): vwap exp %h got %h, saturated exp %b got %b",
                  results_checked, what, want.vwap, rsp_vwap, want.saturated,
                  rsp_saturated);
   endtask

   // Input driver: advance at the falling edge. A bar stays on the port until the
   // monitor has counted it as taken; only then drop valid for the gap or move on.
   int unsigned idle_left = 0;

   always @(negedge clock) begin
      bar_type nb;
      if (!reset && bars_accepted == bars_offered) begin
         if (idle_left > 0) begin
            req_valid <= 1'b0;
            idle_left--;
         end else if (bar_queue.size() != 0
                      && !(bar_queue[0].drain_first && vwap_expected.size() != 0)) begin
            nb = bar_queue.pop_front();
            req_high_price  <= nb.px_high;
            req_low_price   <= nb.px_low;
            req_close_price <= nb.px_close;
            req_volume      <= nb.qty;
            req_session_tag <= nb.tag;
            req_valid       <= 1'b1;
            bars_offered++;
            idle_left = nb.gap_after;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: ready high most of the time with occasional short stalls, a few long
   // ones, calm stretches with ready held high, and one long hold-off so the block backs up into its input.
   int unsigned ready_idle = 0;
   int unsigned calm_left = 0;
   bit          hold_done = 1'b0;

   always @(negedge clock) begin
      int unsigned r;
      if (!reset) begin
         if (!hold_done && results_checked >= hold_at) begin
            hold_done = 1'b1;
            ready_idle = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (ready_idle > 0) begin
            ready_idle--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (calm_left > 0) begin
               calm_left--;
            end else begin
               r = $urandom_range(0, 99);
               if (r < 3)
                  calm_left = $urandom_range(50, 400);
               else if (r < 15)
                  ready_idle = $urandom_range(1, 4);
               else if (r < 17)
                  ready_idle = $urandom_range(20, 120);
            end
         end
      end
   end

   // Monitor: sample both channels at the rising edge. A taken bar is run through
   // the accumulator right away; a taken result is checked against the oldest average.
   always @(posedge clock) begin
      bar_type  taken;
      vwap_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            taken.px_high     = req_high_price;
            taken.px_low      = req_low_price;
            taken.px_close    = req_close_price;
            taken.qty         = req_volume;
            taken.tag         = req_session_tag;
            taken.gap_after   = 0;
            taken.drain_first = 1'b0;
            vwap_expected.push_back(accumulate_bar(taken));
            bars_accepted++;
         end

         if (rsp_valid && rsp_ready) begin
            if (vwap_expected.size() == 0) begin
               want = '{vwap: 'x, saturated: 1'bx};
               log_mismatch("result with no bar pending", want);
            end else begin
               want = vwap_expected.pop_front();
               if (rsp_vwap !== want.vwap || rsp_saturated !== want.saturated)
                  log_mismatch("field differs", want);
            end
            results_checked++;
         end

         // watchdog: nothing moving on either side for too long means a hang
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      int unsigned        r;
      int unsigned        run;
      int unsigned        gap;
      int unsigned        random_bars;
      logic [TAG_W-1:0]   session_tag;
      logic [PRICE_W-1:0] base;
      logic [VOL_W-1:0]   qty;

      // Directed bars. The first one follows reset and has no volume, so zero.
      queue_bar('0, '0, '0, '0, 32'h0, 0, 1'b0);
      queue_bar(PX_MAX, PX_MAX, PX_MAX, VOL_MAX, 32'h0, 0, 1'b0);
      queue_bar('0, '0, '0, VOL_MAX, 32'h0, 3, 1'b0);
      queue_bar(PX_MAX, '0, '0, 24'd1, 32'h0, 0, 1'b0);
      // tag change on a zero-volume bar: sums restart and the average is zero
      queue_bar(PX_MAX, PX_MAX, PX_MAX, '0, 32'h1, 0, 1'b0);
      queue_bar(24'd1, '0, '0, 24'd1, 32'h1, 0, 1'b0);
      queue_bar(24'd2, 24'd2, 24'd3, 24'd7, 32'h1, 0, 1'b0);
      queue_bar(PX_MAX, '0, 24'h7FFFFF, 24'd1, 32'hFFFFFFFF, 2, 1'b0);
      queue_bar(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 32'hFFFFFFFF, 0, 1'b0);
      // a zero-volume bar inside a session leaves the average where it was
      queue_bar('0, '0, '0, '0, 32'hFFFFFFFF, 0, 1'b0);
      queue_bar(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 32'hAAAA5555, 0, 1'b1);
      queue_bar(24'h123456, 24'h654321, 24'hFEDCBA, 24'h800000, 32'h5555AAAA, 1, 1'b0);
      queue_bar(24'h000001, PX_MAX, 24'h800000, VOL_MAX, 32'h0, 0, 1'b0);
      queue_bar(PX_MAX, PX_MAX, PX_MAX, 24'd1, 32'h0, 0, 1'b0);
      // zero prices with volume: the division runs and yields zero
      queue_bar('0, '0, '0, VOL_MAX, 32'h80000000, 0, 1'b0);

      // A session at full price and volume, back to back, so the sums grow large;
      // then a zero-volume bar inside it, another bar, and a restart on a new tag.
      for (int k = 0; k < FULL_BARS; k++)
         queue_bar(PX_MAX, PX_MAX, PX_MAX, VOL_MAX, 32'h13579BDF, 0, k == 0);
      queue_bar('0, '0, '0, '0, 32'h13579BDF, 0, 1'b0);
      queue_bar(24'd5, 24'd1, 24'd3, VOL_MAX, 32'h13579BDF, 0, 1'b0);
      queue_bar(24'd5, 24'd1, 24'd3, 24'd9, 32'h2468ACE0, 0, 1'b0);

      // Random sessions: runs of bars sharing a tag around a base price. A new
      // run sometimes keeps the old tag, and single-bar runs flip the tag often.
      hold_at = bar_queue.size() + 40;
      session_tag = 32'h2468ACE0;
      random_bars = 0;
      while (random_bars < RANDOM_BARS) begin
         r = $urandom_range(0, 99);
         if (r < 10)
            session_tag = session_tag;
         else if (r < 20)
            session_tag = '0;
         else if (r < 25)
            session_tag = '1;
         else
            session_tag = $urandom;
         base = PRICE_W'($urandom);
         run = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 30);
         for (int k = 0; k < run; k++) begin
            r = $urandom_range(0, 99);
            if (r < 8)
               qty = '0;
            else if (r < 12)
               qty = '1;
            else if (r < 45)
               qty = VOL_W'($urandom_range(1, 200));
            else
               qty = VOL_W'($urandom);
            r = $urandom_range(0, 99);
            if (r < 65)
               gap = 0;
            else if (r < 94)
               gap = $urandom_range(1, 5);
            else
               gap = $urandom_range(20, 150);
            queue_bar(near_price(base), near_price(base), near_price(base), qty, session_tag,
                      gap, $urandom_range(0, 99) == 0);
            random_bars++;
         end
      end

      // hold reset, then release it at a falling edge
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (bar_queue.size() != 0 || bars_accepted != bars_offered
             || vwap_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

>>> sim.f
sv/svwap_pkg.sv
sv/svwap_div.sv
sv/session_vwap.sv
sim/session_vwap_test.sv
